/* design/balanced_ternary_converter_defines.svh */
`ifndef BALANCED_TERNARY_CONVERTER_DEFINES_SVH
`define BALANCED_TERNARY_CONVERTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BTC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BTC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/btc_pkg.sv */
`timescale 1ns / 1ps
package btc_pkg;

    localparam int MAX_TRITS = 20;

    localparam logic [1:0] TRIT_ZERO = 2'b00;
    localparam logic [1:0] TRIT_POS  = 2'b01;
    localparam logic [1:0] TRIT_NEG  = 2'b10;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // (3^20 - 1) / 2, 3^20 and 2 * 3^20
    localparam logic [32:0] HALF_RANGE   = 33'd1743392200;
    localparam logic [32:0] FULL_RANGE   = 33'd3486784401;
    localparam logic [32:0] DOUBLE_RANGE = 33'd6973568802;

    typedef struct packed {
        logic       valid;
        logic       mode;
        logic [4:0] width;
    } btc_ctl_t;

    typedef struct packed {
        logic [31:0] acc;
        logic [39:0] trits;
        logic [4:0]  count;
    } btc_data_t;

    function automatic logic [31:0] pow3(input logic [4:0] idx);
        logic [31:0] p;
        case (idx)
            5'd0:    p = 32'd1;
            5'd1:    p = 32'd3;
            5'd2:    p = 32'd9;
            5'd3:    p = 32'd27;
            5'd4:    p = 32'd81;
            5'd5:    p = 32'd243;
            5'd6:    p = 32'd729;
            5'd7:    p = 32'd2187;
            5'd8:    p = 32'd6561;
            5'd9:    p = 32'd19683;
            5'd10:   p = 32'd59049;
            5'd11:   p = 32'd177147;
            5'd12:   p = 32'd531441;
            5'd13:   p = 32'd1594323;
            5'd14:   p = 32'd4782969;
            5'd15:   p = 32'd14348907;
            5'd16:   p = 32'd43046721;
            5'd17:   p = 32'd129140163;
            5'd18:   p = 32'd387420489;
            5'd19:   p = 32'd1162261467;
            default: p = 32'd0;
        endcase
        return p;
    endfunction

endpackage

/* design/balanced_ternary_converter.sv */
`timescale 1ns / 1ps
// Balanced ternary converter. One word is taken on every clock at which start is high
// (busy is never raised), and its result appears on trits_out, value_out and
// nonzero_count, marked by done for a single cycle; the receiver cannot stall it. The
// word passes along the digit chain: an input register, an offset add, a reduction
// modulo 3^20, then one register stage per trit, most significant first, and an output
// register. Encoding adds (3^20 - 1) / 2 so that the ordinary ternary digits of the
// sum, less one, are the balanced trits. trit_width may only be written while no word
// is in flight.
`include "balanced_ternary_converter_defines.svh"
module balanced_ternary_converter
    import btc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [4:0]         cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic signed [31:0] value_in,
    input  logic [39:0]        trits_in,
    output logic               done,
    output logic [39:0]        trits_out,
    output logic signed [31:0] value_out,
    output logic [4:0]         nonzero_count
);

    localparam int LATENCY = MAX_TRITS + 4;

    logic [4:0]  trit_width_reg;
    logic [4:0]  width_eff;

    btc_ctl_t    ctl_a_reg;
    logic [31:0] value_a_reg;
    logic [39:0] trits_a_reg;

    btc_ctl_t    ctl_b_reg;
    logic [32:0] sum_b_reg;
    logic [32:0] sum_b_next;
    logic [39:0] trits_b_reg;

    btc_ctl_t    ctl_c_reg;
    btc_data_t   data_c_reg;
    btc_data_t   data_c_next;

    btc_ctl_t    stage_ctl  [0:MAX_TRITS];
    btc_data_t   stage_data [0:MAX_TRITS];

    logic        done_reg;
    logic [39:0] trits_out_reg;
    logic [31:0] value_out_reg;
    logic [4:0]  count_out_reg;

    assign busy      = 1'b0;
    assign width_eff = (trit_width_reg > 5'(MAX_TRITS)) ? 5'(MAX_TRITS) : trit_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trit_width_reg <= 5'd20;
        end
        else if (cfg_write)
        begin
            trit_width_reg <= cfg_data;
        end
    end

    // control path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ctl_a_reg.valid <= start;
            ctl_a_reg.mode  <= mode;
            ctl_a_reg.width <= width_eff;
            ctl_b_reg       <= ctl_a_reg;
            ctl_c_reg       <= ctl_b_reg;
            done_reg        <= stage_ctl[MAX_TRITS].valid;
        end
    end

    always_comb
    begin
        // offset plus 3^20 keeps the sum positive and below 2^33
        sum_b_next = {value_a_reg[31], value_a_reg} + HALF_RANGE + FULL_RANGE;
        if (ctl_a_reg.mode == MODE_DECODE)
        begin
            sum_b_next = '0;
        end
        data_c_next.trits = trits_b_reg;
        data_c_next.count = 5'd0;
        if (sum_b_reg >= DOUBLE_RANGE)
        begin
            data_c_next.acc = 32'(sum_b_reg - DOUBLE_RANGE);
        end
        else if (sum_b_reg >= FULL_RANGE)
        begin
            data_c_next.acc = 32'(sum_b_reg - FULL_RANGE);
        end
        else
        begin
            data_c_next.acc = sum_b_reg[31:0];
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        value_a_reg <= value_in;
        trits_a_reg <= (mode == MODE_DECODE) ? trits_in : 40'd0;
        sum_b_reg   <= sum_b_next;
        trits_b_reg <= trits_a_reg;
        data_c_reg  <= data_c_next;
    end

    assign stage_ctl[0]  = ctl_c_reg;
    assign stage_data[0] = data_c_reg;

    for (genvar k = 0; k < MAX_TRITS; k++)
    begin : g_digit
        btc_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .digit    (5'(MAX_TRITS - 1 - k)),
            .ctl_in   (stage_ctl[k]),
            .data_in  (stage_data[k]),
            .ctl_out  (stage_ctl[k + 1]),
            .data_out (stage_data[k + 1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (stage_ctl[MAX_TRITS].mode == MODE_ENCODE)
        begin
            trits_out_reg <= stage_data[MAX_TRITS].trits;
            value_out_reg <= 32'd0;
            count_out_reg <= stage_data[MAX_TRITS].count;
        end
        else
        begin
            trits_out_reg <= 40'd0;
            value_out_reg <= stage_data[MAX_TRITS].acc;
            count_out_reg <= 5'd0;
        end
    end

    assign done          = done_reg;
    assign trits_out     = trits_out_reg;
    assign value_out     = value_out_reg;
    assign nonzero_count = count_out_reg;

    `BTC_ASSERT_IMP(a_done_latency, done, $past(start, LATENCY), "word out without word in")
    `BTC_ASSERT_IMP(a_decode_clean, done && (value_out != 32'd0), (trits_out == 40'd0) && (nonzero_count == 5'd0), "decode word carries encode fields")
    `BTC_ASSERT_IMP(a_count_range, done, nonzero_count <= 5'(MAX_TRITS), "nonzero count out of range")
    `BTC_ASSERT_NXT(a_done_pulse, stage_ctl[MAX_TRITS].valid, done, "pipeline word not delivered")

endmodule

/* design/btc_stage.sv */
`timescale 1ns / 1ps
module btc_stage
    import btc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [4:0] digit,
    input  btc_ctl_t  ctl_in,
    input  btc_data_t data_in,
    output btc_ctl_t  ctl_out,
    output btc_data_t data_out
);

    btc_ctl_t    ctl_reg;
    btc_data_t   data_reg;
    btc_data_t   data_next;
    logic [31:0] pow_w;
    logic [32:0] pow2_w;
    logic [5:0]  pos;
    logic        active;
    logic        ge_two;
    logic        ge_one;
    logic [1:0]  code_in;
    logic [1:0]  code_enc;

    always_comb
    begin
        pow_w   = pow3(digit);
        pow2_w  = {pow_w, 1'b0};
        pos     = {digit, 1'b0};
        active  = digit < ctl_in.width;
        ge_two  = {1'b0, data_in.acc} >= pow2_w;
        ge_one  = data_in.acc >= pow_w;
        code_in = data_in.trits[pos +: 2];
        data_next = data_in;
        code_enc  = TRIT_ZERO;
        if (ctl_in.mode == MODE_ENCODE)
        begin
            // remainder is offset by one per digit: 2 -> +1, 1 -> 0, 0 -> -1
            if (ge_two)
            begin
                code_enc      = TRIT_POS;
                data_next.acc = data_in.acc - pow2_w[31:0];
            end
            else if (ge_one)
            begin
                code_enc      = TRIT_ZERO;
                data_next.acc = data_in.acc - pow_w;
            end
            else
            begin
                code_enc = TRIT_NEG;
            end
            data_next.trits[pos +: 2] = active ? code_enc : TRIT_ZERO;
            if (active && (code_enc != TRIT_ZERO))
            begin
                data_next.count = data_in.count + 5'd1;
            end
        end
        else if (active)
        begin
            case (code_in)
                TRIT_POS: data_next.acc = data_in.acc + pow_w;
                TRIT_NEG: data_next.acc = data_in.acc - pow_w;
                default:  data_next.acc = data_in.acc;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign ctl_out  = ctl_reg;
    assign data_out = data_reg;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import btc_pkg::*;

    localparam int PHASES        = 10;
    localparam int WORDS_PER_PHASE = 115;
    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 2000;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [4:0]         cfg_data;
    logic               start;
    logic               busy;
    logic               mode;
    logic signed [31:0] value_in;
    logic [39:0]        trits_in;
    logic               done;
    logic [39:0]        trits_out;
    logic signed [31:0] value_out;
    logic [4:0]         nonzero_count;

    class ternary_scoreboard;
        typedef struct {
            logic [39:0]        trits;
            logic signed [31:0] value;
            logic [4:0]         nz;
        } conversion_t;

        conversion_t conversion_q[$];
        int          cur_width  = MAX_TRITS;
        int          mismatches = 0;
        int          words      = 0;
        int          checked    = 0;

        function int trits_used();
            return (cur_width > MAX_TRITS) ? MAX_TRITS : cur_width;
        endfunction

        function void encode_word(input logic signed [31:0] val, input int w,
                                  output logic [39:0] trits, output logic [4:0] nz);
            longint v;
            longint r;
            int     i;
            v     = longint'(val);
            trits = '0;
            nz    = '0;
            for (i = 0; i < w; i++)
            begin
                r = v % 3;
                if (r < 0)
                    r += 3;
                if (r == 2)
                begin
                    trits[2*i +: 2] = TRIT_NEG;
                    v = (v + 1) / 3;
                    nz++;
                end
                else if (r == 1)
                begin
                    trits[2*i +: 2] = TRIT_POS;
                    v = (v - 1) / 3;
                    nz++;
                end
                else
                begin
                    v = v / 3;
                end
            end
        endfunction

        function logic signed [31:0] decode_word(input logic [39:0] trits, input int w);
            longint     acc;
            int         i;
            logic [1:0] digit;
            acc = 0;
            // most significant trit first; code 11 falls through as zero
            for (i = w - 1; i >= 0; i--)
            begin
                digit = trits[2*i +: 2];
                acc = acc * 3;
                if (digit == TRIT_POS)
                    acc += 1;
                else if (digit == TRIT_NEG)
                    acc -= 1;
            end
            return acc[31:0];
        endfunction

        function void note_word(input logic m, input logic signed [31:0] val,
                                input logic [39:0] trits);
            conversion_t c;
            c.trits = '0;
            c.value = '0;
            c.nz    = '0;
            if (m == MODE_ENCODE)
                encode_word(val, trits_used(), c.trits, c.nz);
            else
                c.value = decode_word(trits, trits_used());
            conversion_q.push_back(c);
            words++;
        endfunction

        function void check_result(input logic [39:0] trits, input logic signed [31:0] val,
                                   input logic [4:0] nz);
            conversion_t c;
            if (conversion_q.size() == 0)
            begin
                $error("result word with nothing expected");
                mismatches++;
                return;
            end
            c = conversion_q.pop_front();
            checked++;
            if (trits !== c.trits)
            begin
                $error("trits_out: expected %h, got %h", c.trits, trits);
                mismatches++;
            end
            if (val !== c.value)
            begin
                $error("value_out: expected %0d, got %0d", c.value, val);
                mismatches++;
            end
            if (nz !== c.nz)
            begin
                $error("nonzero_count: expected %0d, got %0d", c.nz, nz);
                mismatches++;
            end
        endfunction
    endclass

    ternary_scoreboard sb = new();

    int          idle_pct;
    int          stall_cycles;
    logic [31:0] widths_seen;

    balanced_ternary_converter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .value_in      (value_in),
        .trits_in      (trits_in),
        .done          (done),
        .trits_out     (trits_out),
        .value_out     (value_out),
        .nonzero_count (nonzero_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_word(mode, value_in, trits_in);
            if (done)
                sb.check_result(trits_out, value_out, nonzero_count);
        end
    end

    // watchdog: cycles with neither a word in nor a result out
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic m, input logic signed [31:0] val,
                             input logic [39:0] trits);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        mode     <= m;
        value_in <= val;
        trits_in <= trits;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.conversion_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_width(input int w);
        drain();
        cfg_write <= 1'b1;
        cfg_data  <= w[4:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.cur_width = w;
        widths_seen[w] = 1'b1;
    endtask

    function automatic longint half_span(input int w);
        longint p;
        p = 1;
        repeat (w) p *= 3;
        return (p - 1) / 2;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int     w;
        longint v;
        w = sb.trits_used();
        case ($urandom_range(0, 5))
            0: v = longint'($urandom_range(0, 80)) - 40;
            1: v = half_span(w) + longint'($urandom_range(0, 4)) - 2;
            2: v = -half_span(w) + longint'($urandom_range(0, 4)) - 2;
            3:
            begin
                case ($urandom_range(0, 3))
                    0: v = 64'sh7fffffff;
                    1: v = -64'sd2147483648;
                    2: v = longint'(HALF_RANGE);
                    default: v = -longint'(HALF_RANGE);
                endcase
            end
            default: v = longint'($signed($urandom));
        endcase
        return v[31:0];
    endfunction

    function automatic logic [39:0] pick_trits();
        logic [39:0] t;
        int          i;
        t = 40'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0, 1:
            begin
                // well-formed digits only
                for (i = 0; i < MAX_TRITS; i++)
                begin
                    case ($urandom_range(0, 2))
                        0: t[2*i +: 2] = TRIT_ZERO;
                        1: t[2*i +: 2] = TRIT_POS;
                        default: t[2*i +: 2] = TRIT_NEG;
                    endcase
                end
            end
            2: t = {MAX_TRITS{($urandom_range(0, 1) == 0) ? TRIT_POS : TRIT_NEG}};
            default: ;
        endcase
        return t;
    endfunction

    initial
    begin
        int phase_width[PHASES];
        int p;
        int n;

        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_data    = '0;
        start       = 1'b0;
        mode        = MODE_ENCODE;
        value_in    = '0;
        trits_in    = '0;
        idle_pct    = 0;
        widths_seen = '0;
        widths_seen[MAX_TRITS] = 1'b1;

        phase_width = '{0, 1, 20, 31, 21, 2, 0, 0, 0, 0};
        for (p = 6; p < PHASES; p++)
            phase_width[p] = $urandom_range(1, 20);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset width, full range
        send_word(MODE_ENCODE, 32'sd0, 40'({$urandom, $urandom}));
        send_word(MODE_ENCODE, 32'sd1, 40'({$urandom, $urandom}));
        send_word(MODE_ENCODE, -32'sd1, 40'({$urandom, $urandom}));
        send_word(MODE_ENCODE, 32'sh7fffffff, 40'({$urandom, $urandom}));
        send_word(MODE_ENCODE, 32'sh80000000, 40'({$urandom, $urandom}));
        send_word(MODE_ENCODE, HALF_RANGE[31:0], 40'({$urandom, $urandom}));
        send_word(MODE_ENCODE, -$signed(HALF_RANGE[31:0]), 40'({$urandom, $urandom}));
        send_word(MODE_ENCODE, HALF_RANGE[31:0] + 32'd1, 40'({$urandom, $urandom}));
        send_word(MODE_ENCODE, -$signed(HALF_RANGE[31:0]) - 32'sd1,
                  40'({$urandom, $urandom}));
        send_word(MODE_DECODE, $urandom, 40'h0);
        send_word(MODE_DECODE, $urandom, 40'h5555555555);
        send_word(MODE_DECODE, $urandom, 40'hAAAAAAAAAA);
        send_word(MODE_DECODE, $urandom, 40'hFFFFFFFFFF);

        // width zero converts nothing
        write_width(0);
        send_word(MODE_ENCODE, 32'sh80000000, 40'({$urandom, $urandom}));
        send_word(MODE_DECODE, $urandom, 40'hAAAAAAAAAA);

        // widths above the maximum saturate
        write_width(31);
        send_word(MODE_ENCODE, 32'sh7fffffff, 40'({$urandom, $urandom}));
        send_word(MODE_DECODE, $urandom, 40'h5555555555);

        // single trit: upper value dropped, upper input bits ignored, code 11 is zero
        write_width(1);
        send_word(MODE_ENCODE, 32'sd2, 40'({$urandom, $urandom}));
        send_word(MODE_ENCODE, -32'sd2, 40'({$urandom, $urandom}));
        send_word(MODE_DECODE, $urandom, 40'hAAAAAAAAA7);

        for (p = 0; p < PHASES; p++)
        begin
            write_width(phase_width[p]);
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 54;
                default: idle_pct = 13;
            endcase
            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_word(MODE_ENCODE, pick_value(), 40'({$urandom, $urandom}));
                else
                    send_word(MODE_DECODE, $urandom, pick_trits());
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("converted %0d words in both directions, %0d results checked",
                 sb.words, sb.checked);
        $display("trit_width settings used (bit mask): %b, sender idling 0/13/54 percent",
                 widths_seen);
        if (sb.mismatches == 0 && sb.conversion_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
